[rtl/core/biquad_cascade_iir_filter_macros.svh]
// ----------------------------------------------------------------------------
// biquad cascade filter assertion macros
// shared concurrent assertion forms for the filter checker
// ----------------------------------------------------------------------------
`ifndef BIQUAD_CASCADE_IIR_FILTER_MACROS_SVH
`define BIQUAD_CASCADE_IIR_FILTER_MACROS_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define BQC_ASSERT_NOW(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// next-cycle implication, checked on every rising clock edge outside reset
`define BQC_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

[rtl/core/bqc_pkg.sv]
// ----------------------------------------------------------------------------
// bqc_pkg
// types and constants shared by the biquad cascade filter modules
// ----------------------------------------------------------------------------
`default_nettype none

package bqc_pkg;

  // field widths
  localparam int COEF_W   = 32;
  localparam int HIST_W   = 40;
  localparam int COEF_PER_SEC = 5;

  // item kinds carried in tuser
  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  // term codes, also the coefficient slot codes
  typedef logic [2:0] term_t;
  localparam term_t TERM_B0 = 3'd0;
  localparam term_t TERM_B1 = 3'd1;
  localparam term_t TERM_B2 = 3'd2;
  localparam term_t TERM_A1 = 3'd3;
  localparam term_t TERM_A2 = 3'd4;

  // per-section sequencer phases: terms issue in phases 0..4
  localparam term_t PHASE_LAST = 3'd6;

  // section output saturation bounds
  localparam logic signed [HIST_W-1:0] Y_MAX = {1'b0, {(HIST_W-1){1'b1}}};
  localparam logic signed [HIST_W-1:0] Y_MIN = {1'b1, {(HIST_W-1){1'b0}}};

  // output scaling
  localparam logic signed [47:0] OUT_SCALE  = 48'sd100;
  localparam logic signed [47:0] ROUND_HALF = 48'sd32768;
  localparam logic signed [31:0] Q_MAX = 32'sd32767;
  localparam logic signed [31:0] Q_MIN = -32'sd32768;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_SCALE,
    ST_EMIT
  } state_t;

  // history row of one section
  typedef struct packed {
    logic signed [HIST_W-1:0] x1;
    logic signed [HIST_W-1:0] x2;
    logic signed [HIST_W-1:0] y1;
    logic signed [HIST_W-1:0] y2;
  } hist_row_t;

  // tag that travels down the mac pipeline with each term
  typedef struct packed {
    logic  valid;
    term_t term;
    logic  last;
  } tag_t;

  // section result strobe from the mac
  typedef struct packed {
    logic valid;
    logic last;
  } fin_t;

endpackage

`default_nettype wire

[rtl/core/bqc_coef_mem.sv]
// ----------------------------------------------------------------------------
// bqc_coef_mem
// coefficient store, one entry per section and slot, registered read
// ----------------------------------------------------------------------------
`default_nettype none

module bqc_coef_mem #(
  parameter int SECTIONS = 10
) (
  input  wire                                    clk,
  input  wire                                    rst,
  input  wire                                    wr_en,
  input  wire  [$clog2(SECTIONS*5)-1:0]          wr_addr,
  input  wire  signed [bqc_pkg::COEF_W-1:0]      wr_data,
  input  wire  [$clog2(SECTIONS*5)-1:0]          rd_addr,
  output logic signed [bqc_pkg::COEF_W-1:0]      rd_data
);

  localparam int DEPTH = SECTIONS * bqc_pkg::COEF_PER_SEC;

  logic signed [bqc_pkg::COEF_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]                  entry_valid;

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (wr_en) begin
      entry_valid[wr_addr] <= 1'b1;
    end
  end

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= entry_valid[rd_addr] ? mem[rd_addr] : '0;
  end

endmodule

`default_nettype wire

[rtl/core/bqc_hist_mem.sv]
// ----------------------------------------------------------------------------
// bqc_hist_mem
// section history store, one row of x1, x2, y1, y2 per section
// ----------------------------------------------------------------------------
`default_nettype none

module bqc_hist_mem #(
  parameter int SECTIONS = 10
) (
  input  wire                                         clk,
  input  wire                                         rst,
  input  wire                                         wr_en,
  input  wire  [(SECTIONS > 1 ? $clog2(SECTIONS) : 1)-1:0] wr_addr,
  input  bqc_pkg::hist_row_t                          wr_data,
  input  wire  [(SECTIONS > 1 ? $clog2(SECTIONS) : 1)-1:0] rd_addr,
  output bqc_pkg::hist_row_t                          rd_data
);

  bqc_pkg::hist_row_t mem [SECTIONS];
  logic [SECTIONS-1:0] row_valid;

  // rows never written read as zero history
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[wr_addr] <= 1'b1;
    end
  end

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= row_valid[rd_addr] ? mem[rd_addr] : '0;
  end

endmodule

`default_nettype wire

[rtl/core/bqc_mac.sv]
// ----------------------------------------------------------------------------
// bqc_mac
// shared multiply-accumulate unit, one biquad term per cycle, then rescale
// ----------------------------------------------------------------------------
`default_nettype none

module bqc_mac (
  input  wire                                  clk,
  input  wire                                  rst,
  input  bqc_pkg::tag_t                        tag_b,
  input  wire  signed [bqc_pkg::COEF_W-1:0]    coef,
  input  wire  signed [bqc_pkg::HIST_W-1:0]    x,
  output bqc_pkg::fin_t                        fin,
  output logic signed [bqc_pkg::HIST_W-1:0]    y
);

  bqc_pkg::tag_t     tag_c;
  bqc_pkg::fin_t     tag_d;
  logic signed [52:0] p_lo;
  logic signed [51:0] p_hi;
  logic signed [55:0] acc_lo;
  logic signed [54:0] acc_hi;
  logic signed [20:0] x_lo;
  logic signed [19:0] x_hi;
  logic signed [75:0] sum;
  logic               minus;

  // split the operand so each product stays near 32 by 20 bits
  assign x_lo = $signed({1'b0, x[19:0]});
  assign x_hi = x[39:20];

  // product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_c <= '0;
    end else begin
      tag_c <= tag_b;
    end
  end

  always_ff @(posedge clk) begin
    p_lo <= 53'(coef) * 53'(x_lo);
    p_hi <= 52'(coef) * 52'(x_hi);
  end

  // feedback terms are subtracted
  assign minus = (tag_c.term == bqc_pkg::TERM_A1) || (tag_c.term == bqc_pkg::TERM_A2);

  // accumulate stage, first term of a section loads
  always_ff @(posedge clk) begin
    if (tag_c.valid) begin
      if (tag_c.term == bqc_pkg::TERM_B0) begin
        acc_lo <= 56'(p_lo);
        acc_hi <= 55'(p_hi);
      end else if (minus) begin
        acc_lo <= acc_lo - 56'(p_lo);
        acc_hi <= acc_hi - 55'(p_hi);
      end else begin
        acc_lo <= acc_lo + 56'(p_lo);
        acc_hi <= acc_hi + 55'(p_hi);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_d <= '0;
    end else begin
      tag_d.valid <= tag_c.valid && (tag_c.term == bqc_pkg::TERM_A2);
      tag_d.last  <= tag_c.last;
    end
  end

  // recombine halves, floor by 2^28, saturate to 40 bits
  always_comb begin
    sum = (76'(acc_hi) <<< 20) + 76'(acc_lo);
    if (sum[75:67] == {9{sum[67]}}) begin
      y = sum[67:28];
    end else if (sum[75]) begin
      y = bqc_pkg::Y_MIN;
    end else begin
      y = bqc_pkg::Y_MAX;
    end
  end

  assign fin = tag_d;

endmodule

`default_nettype wire

[rtl/core/biquad_cascade_iir_filter.sv]
// ----------------------------------------------------------------------------
// biquad_cascade_iir_filter
// cascade of direct-form-I biquad sections on one shared mac and two memories
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries items; tuser[0] selects the kind. A coefficient write
//   (tuser[0] = 1) stores one Q3.28 coefficient and gives no result;
//   writes to a section or slot out of range are dropped.
//   A filter item (tuser[0] = 0) runs the sample through all sections and
//   gives one result on m_axis: filtered in tdata, saturated in tuser[0].
// Sequencing:
//   each section issues five terms through the mac, then waits while the
//   last term clears the product and accumulate stages; the next item is
//   taken only after the result has gone to the output register.
//   Each section's first term waits for the previous section's output.
// Reset:
//   valid bits in both memories clear at once, so all history and all
//   coefficients read as zero right after reset; no clearing pass is run.
// Stall:
//   the result waits in the output register; a new item is still taken, and
//   the next filter item holds in its final step until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module biquad_cascade_iir_filter #(
  parameter int SECTIONS = 10
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // sample[7:0], coef_section[11:8], coef_slot[14:12], coef_value[46:15], zero
  input  wire  [47:0] s_axis_tdata,
  // operation[0]
  input  wire  [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // filtered[15:0]
  output logic [15:0] m_axis_tdata,
  // saturated[0]
  output logic [0:0]  m_axis_tuser
);

  localparam int SW    = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int CDEPTH = SECTIONS * bqc_pkg::COEF_PER_SEC;
  localparam int CAW   = $clog2(CDEPTH);

  // input fields
  logic                              operation;
  logic [7:0]                        sample;
  logic [3:0]                        coef_section;
  logic [2:0]                        coef_slot;
  logic signed [bqc_pkg::COEF_W-1:0] coef_value;

  assign operation    = s_axis_tuser[0];
  assign sample       = s_axis_tdata[7:0];
  assign coef_section = s_axis_tdata[11:8];
  assign coef_slot    = s_axis_tdata[14:12];
  assign coef_value   = s_axis_tdata[46:15];

  bqc_pkg::state_t state, state_next;

  logic [2:0]     phase;
  logic [SW-1:0]  sec;
  logic [SW-1:0]  hist_sec;
  logic [CAW-1:0] cidx;
  logic           sec_last;
  logic           accept;
  logic           issue;
  logic           out_free;

  logic signed [bqc_pkg::HIST_W-1:0] sig;
  logic signed [bqc_pkg::HIST_W-1:0] x_b;
  logic signed [bqc_pkg::HIST_W-1:0] y;
  logic signed [bqc_pkg::COEF_W-1:0] coef_rd;
  logic signed [47:0]                v;
  logic signed [31:0]                q_trunc;
  logic signed [15:0]                q_sat;
  logic                              q_clip;

  bqc_pkg::hist_row_t hist_rd;
  bqc_pkg::hist_row_t row_hold;
  bqc_pkg::hist_row_t hist_wr;
  bqc_pkg::tag_t      tag_b;
  bqc_pkg::fin_t      fin;

  logic           cw_en;
  logic [7:0]     cw_addr_full;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign sec_last = (sec == SW'(SECTIONS - 1));
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // coefficient write decode
  assign cw_en = accept && (operation == bqc_pkg::OP_COEF)
                 && (32'(coef_section) < SECTIONS)
                 && (32'(coef_slot) < bqc_pkg::COEF_PER_SEC);
  assign cw_addr_full = (8'(coef_section) << 2) + 8'(coef_section) + 8'(coef_slot);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bqc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bqc_pkg::ST_IDLE: begin
        if (accept && (operation == bqc_pkg::OP_FILTER)) state_next = bqc_pkg::ST_RUN;
      end
      bqc_pkg::ST_RUN: begin
        if ((phase == bqc_pkg::PHASE_LAST) && sec_last) state_next = bqc_pkg::ST_DRAIN;
      end
      bqc_pkg::ST_DRAIN: begin
        if (fin.valid && fin.last) state_next = bqc_pkg::ST_SCALE;
      end
      bqc_pkg::ST_SCALE: begin
        state_next = bqc_pkg::ST_EMIT;
      end
      bqc_pkg::ST_EMIT: begin
        if (out_free) state_next = bqc_pkg::ST_IDLE;
      end
      default: state_next = bqc_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready = 1'b0;
    issue         = 1'b0;
    unique case (state)
      bqc_pkg::ST_IDLE:  s_axis_tready = 1'b1;
      bqc_pkg::ST_RUN:   issue = (phase <= bqc_pkg::TERM_A2);
      bqc_pkg::ST_DRAIN,
      bqc_pkg::ST_SCALE,
      bqc_pkg::ST_EMIT:  issue = 1'b0;
      default:           issue = 1'b0;
    endcase
  end

  // sequencer counters
  always_ff @(posedge clk) begin
    if (state == bqc_pkg::ST_IDLE) begin
      phase <= '0;
      sec   <= '0;
      cidx  <= '0;
    end else if (state == bqc_pkg::ST_RUN) begin
      if (phase == bqc_pkg::PHASE_LAST) begin
        phase <= '0;
        if (!sec_last) sec <= sec + 1'b1;
      end else begin
        phase <= phase + 1'b1;
      end
      if (issue) begin
        cidx <= (cidx == CAW'(CDEPTH - 1)) ? '0 : cidx + 1'b1;
      end
    end
  end

  // tag aligned with memory read data
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_b <= '0;
    end else begin
      tag_b.valid <= issue;
      tag_b.term  <= phase;
      tag_b.last  <= sec_last;
    end
  end

  // hold the section's history row and index while its terms go through the mac
  always_ff @(posedge clk) begin
    if (tag_b.valid && (tag_b.term == bqc_pkg::TERM_B0)) begin
      row_hold <= hist_rd;
      hist_sec <= sec;
    end
  end

  // operand select
  always_comb begin
    case (tag_b.term)
      bqc_pkg::TERM_B0: x_b = sig;
      bqc_pkg::TERM_B1: x_b = row_hold.x1;
      bqc_pkg::TERM_B2: x_b = row_hold.x2;
      bqc_pkg::TERM_A1: x_b = row_hold.y1;
      bqc_pkg::TERM_A2: x_b = row_hold.y2;
      default:          x_b = '0;
    endcase
  end

  // signal between sections: sample in, then each section's output
  always_ff @(posedge clk) begin
    if (accept && (operation == bqc_pkg::OP_FILTER)) begin
      sig <= 40'({sample, 16'h0000});
    end else if (fin.valid) begin
      sig <= y;
    end
  end

  // history update; next section reads another row, so no overlap on one entry
  assign hist_wr = '{x1: sig, x2: row_hold.x1, y1: y, y2: row_hold.y1};

  bqc_coef_mem #(
    .SECTIONS (SECTIONS)
  ) u_coef_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cw_en),
    .wr_addr (CAW'(cw_addr_full)),
    .wr_data (coef_value),
    .rd_addr (cidx),
    .rd_data (coef_rd)
  );

  bqc_hist_mem #(
    .SECTIONS (SECTIONS)
  ) u_hist_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (fin.valid),
    .wr_addr (hist_sec),
    .wr_data (hist_wr),
    .rd_addr (sec),
    .rd_data (hist_rd)
  );

  bqc_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .tag_b (tag_b),
    .coef  (coef_rd),
    .x     (x_b),
    .fin   (fin),
    .y     (y)
  );

  // scale by 100 and add one half in Q16
  always_ff @(posedge clk) begin
    if (state == bqc_pkg::ST_SCALE) begin
      v <= 48'(sig) * bqc_pkg::OUT_SCALE + bqc_pkg::ROUND_HALF;
    end
  end

  // truncate toward zero and saturate to int16
  always_comb begin
    q_trunc = v[47:16];
    if (v[47] && (v[15:0] != 16'h0000)) q_trunc = q_trunc + 32'sd1;
    q_clip = 1'b0;
    q_sat  = q_trunc[15:0];
    if (q_trunc > bqc_pkg::Q_MAX) begin
      q_sat  = bqc_pkg::Q_MAX[15:0];
      q_clip = 1'b1;
    end else if (q_trunc < bqc_pkg::Q_MIN) begin
      q_sat  = bqc_pkg::Q_MIN[15:0];
      q_clip = 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state == bqc_pkg::ST_EMIT) && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == bqc_pkg::ST_EMIT) && out_free) begin
      m_axis_tdata    <= q_sat;
      m_axis_tuser[0] <= q_clip;
    end
  end

endmodule

`default_nettype wire

[rtl/core/bqc_checker.sv]
// ----------------------------------------------------------------------------
// bqc_checker
// port-level checks for the biquad cascade filter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "biquad_cascade_iir_filter_macros.svh"

module bqc_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire [47:0] s_axis_tdata,
  input wire [0:0]  s_axis_tuser,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [15:0] m_axis_tdata,
  input wire [0:0]  m_axis_tuser
);

  // stalled result holds
  `BQC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  // a clipped result sits at one of the int16 limits
  `BQC_ASSERT_NOW(a_clip_limit, m_axis_tvalid && m_axis_tuser[0], (m_axis_tdata == 16'h7fff) || (m_axis_tdata == 16'h8000), "saturated flag without limit value")

  // a filter transfer starts the cascade and blocks further input
  `BQC_ASSERT_NEXT(a_filter_busy, s_axis_tvalid && s_axis_tready && !s_axis_tuser[0], !s_axis_tready, "input taken while filtering")

  // a coefficient transfer leaves the input open
  `BQC_ASSERT_NEXT(a_coef_open, s_axis_tvalid && s_axis_tready && s_axis_tuser[0], s_axis_tready, "coefficient write stalled input")

  // a new result only appears from the busy state
  `BQC_ASSERT_NOW(a_result_src, $rose(m_axis_tvalid), $past(!s_axis_tready), "result without filter pass")

endmodule

bind biquad_cascade_iir_filter bqc_checker u_checker (.*);

`default_nettype wire

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench for biquad_cascade_iir_filter
// Drives sample and coefficient-write transfers into the cascade filter and
// checks every filtered reading against a local fixed-point model of the ten
// direct-form-I sections. It starts with a short table of directed items, then
// runs random episodes of coefficient loads and sample bursts under several
// phases of source idling and sink backpressure.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SECTIONS     = 10;
  localparam int RANDOM_ITEMS = 1400;
  localparam int QUIET_LIMIT  = 3000;
  localparam int TAIL_CYCLES  = 7 * SECTIONS + 3 + 20;
  localparam int DIR_ROWS     = 27;

  // q3.28 constants and the q23.16 history bounds
  localparam logic [31:0] COEF_ONE    = 32'h1000_0000;
  localparam logic [31:0] COEF_TOP    = 32'h7FFF_FFFF;
  localparam logic [31:0] COEF_BOT    = 32'h8000_0000;
  localparam int          MILD_SPREAD = 1 << 24;
  localparam logic signed [39:0] HIST_TOP = {1'b0, {39{1'b1}}};
  localparam logic signed [39:0] HIST_BOT = {1'b1, {39{1'b0}}};
  // slot code that no coefficient uses
  localparam bqc_pkg::term_t SLOT_NONE = 3'd7;

  typedef struct packed {
    logic signed [15:0] flt;
    logic               sat;
  } reading_t;

  typedef struct packed {
    logic     known;
    reading_t val;
  } typed_reading_t;

  typedef struct packed {
    logic           op;
    logic [7:0]     smp;
    logic [3:0]     sec;
    bqc_pkg::term_t slot;
    logic [31:0]    val;
    logic           known;
    reading_t       want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  // model state: coefficients and per-section history
  logic signed [31:0] coef_bank [SECTIONS][bqc_pkg::COEF_PER_SEC];
  logic signed [39:0] x1_hist [SECTIONS];
  logic signed [39:0] x2_hist [SECTIONS];
  logic signed [39:0] y1_hist [SECTIONS];
  logic signed [39:0] y2_hist [SECTIONS];

  reading_t       pending_readings [$];
  typed_reading_t typed_readings [$];
  dir_row_t       directed_rows [DIR_ROWS];

  int mismatches  = 0;
  int quiet       = 0;
  int readings_in = 0;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int items       = 0;
  int episode     = 0;

  biquad_cascade_iir_filter #(
    .SECTIONS(SECTIONS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // one sample through all sections, updating history as the hardware does
  function automatic reading_t run_cascade(input logic [7:0] smp);
    reading_t           r;
    logic signed [39:0] sig;
    logic signed [79:0] acc;
    logic signed [63:0] scaled;
    logic signed [63:0] quo;
    sig = {16'd0, smp, 16'd0};
    for (int s = 0; s < SECTIONS; s++) begin
      acc = coef_bank[s][bqc_pkg::TERM_B0] * sig
          + coef_bank[s][bqc_pkg::TERM_B1] * x1_hist[s]
          + coef_bank[s][bqc_pkg::TERM_B2] * x2_hist[s]
          - coef_bank[s][bqc_pkg::TERM_A1] * y1_hist[s]
          - coef_bank[s][bqc_pkg::TERM_A2] * y2_hist[s];
      // floor shift back to q23.16, then clamp to 40 bits
      acc = acc >>> 28;
      x2_hist[s] = x1_hist[s];
      x1_hist[s] = sig;
      y2_hist[s] = y1_hist[s];
      if (acc > HIST_TOP) sig = HIST_TOP;
      else if (acc < HIST_BOT) sig = HIST_BOT;
      else sig = acc[39:0];
      y1_hist[s] = sig;
    end
    // times 100, plus one half, truncated toward zero
    scaled = sig * 64'sd100 + 64'sd32768;
    quo = scaled / 64'sd65536;
    r.sat = 1'b1;
    if (quo > 32767) begin
      r.flt = 16'sh7FFF;
    end else if (quo < -32768) begin
      r.flt = 16'sh8000;
    end else begin
      r.flt = quo[15:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

  // ingress and egress monitor: model update, reading check, idle counting
  always @(posedge clk) begin : scoreboard
    reading_t       got;
    reading_t       want;
    typed_reading_t typed;
    logic [3:0]     sec;
    bqc_pkg::term_t slot;
    if (rst) begin
      for (int s = 0; s < SECTIONS; s++) begin
        for (int k = 0; k < bqc_pkg::COEF_PER_SEC; k++) coef_bank[s][k] = '0;
        x1_hist[s] = '0;
        x2_hist[s] = '0;
        y1_hist[s] = '0;
        y2_hist[s] = '0;
      end
      quiet = 0;
    end else begin
      // egress first: a reading leaving now belongs to an earlier sample
      if (m_axis_tvalid && m_axis_tready) begin
        got.flt = m_axis_tdata;
        got.sat = m_axis_tuser[0];
        readings_in++;
        if (pending_readings.size() == 0) begin
          flag_mismatch($sformatf("reading %0d with nothing pending", readings_in));
        end else begin
          want = pending_readings.pop_front();
          if (got.flt !== want.flt)
            flag_mismatch($sformatf("reading %0d filtered %0d, model %0d",
                                    readings_in, got.flt, want.flt));
          if (got.sat !== want.sat)
            flag_mismatch($sformatf("reading %0d saturated %0b, model %0b",
                                    readings_in, got.sat, want.sat));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser[0] == bqc_pkg::OP_COEF) begin
          sec  = s_axis_tdata[11:8];
          slot = s_axis_tdata[14:12];
          if (sec < SECTIONS && slot <= bqc_pkg::TERM_A2)
            coef_bank[sec][slot] = s_axis_tdata[46:15];
        end else begin
          want = run_cascade(s_axis_tdata[7:0]);
          typed = typed_readings.pop_front();
          if (typed.known && typed.val !== want)
            flag_mismatch($sformatf("model gives %0d/%0b for sample %0d, table says %0d/%0b",
                                    want.flt, want.sat, s_axis_tdata[7:0],
                                    typed.val.flt, typed.val.sat));
          pending_readings.push_back(typed.known ? typed.val : want);
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
  end

  // sink backpressure
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99, 0) >= stall_pct);
  end

  initial begin
    while (quiet < QUIET_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  // one transfer on the slave side, with random source idling ahead of it
  task automatic send_item(input logic op, input logic [7:0] smp, input logic [3:0] sec,
                           input bqc_pkg::term_t slot, input logic [31:0] val,
                           input logic known, input reading_t want);
    typed_reading_t typed;
    while (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    if (op == bqc_pkg::OP_FILTER) begin
      typed.known = known;
      typed.val   = want;
      typed_readings.push_back(typed);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {1'b0, val, slot, sec, smp};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // hold the source until every pending reading has left
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] mild_coef(input bqc_pkg::term_t slot);
    int d;
    d = int'($urandom_range(2 * MILD_SPREAD, 0)) - MILD_SPREAD;
    if (slot == bqc_pkg::TERM_B0) d += int'(COEF_ONE);
    return d;
  endfunction

  // near-unity, stable set for every section
  task automatic load_mild_set();
    for (int s = 0; s < SECTIONS; s++) begin
      for (int k = 0; k <= int'(bqc_pkg::TERM_A2); k++) begin
        send_item(bqc_pkg::OP_COEF, 8'($urandom), 4'(s), bqc_pkg::term_t'(k),
                  mild_coef(bqc_pkg::term_t'(k)), 1'b0, '0);
        items++;
      end
    end
  endtask

  initial begin : stimulus
    dir_row_t       row;
    logic [7:0]     smp;
    logic [3:0]     sec;
    bqc_pkg::term_t slot;
    logic [31:0]    val;
    int             n;
    int             mode;
    int             phase;

    directed_rows = '{
      // zero coefficients after reset give zero
      '{bqc_pkg::OP_FILTER, 8'd255, 4'd0, bqc_pkg::TERM_B0, 32'd0, 1'b1, '{16'sd0, 1'b0}},
      // section out of range and slot out of range are both dropped
      '{bqc_pkg::OP_COEF, 8'd0, 4'd15, bqc_pkg::TERM_B0, COEF_TOP, 1'b0, '0},
      '{bqc_pkg::OP_COEF, 8'd0, 4'd0, SLOT_NONE, COEF_BOT, 1'b0, '0},
      '{bqc_pkg::OP_FILTER, 8'd128, 4'd0, bqc_pkg::TERM_B0, 32'd0, 1'b1, '{16'sd0, 1'b0}},
      // unity gain in every section
      '{bqc_pkg::OP_COEF, 8'd0, 4'd0, bqc_pkg::TERM_B0, COEF_ONE, 1'b0, '0},
      '{bqc_pkg::OP_COEF, 8'd0, 4'd1, bqc_pkg::TERM_B0, COEF_ONE, 1'b0, '0},
      '{bqc_pkg::OP_COEF, 8'd0, 4'd2, bqc_pkg::TERM_B0, COEF_ONE, 1'b0, '0},
      '{bqc_pkg::OP_COEF, 8'd0, 4'd3, bqc_pkg::TERM_B0, COEF_ONE, 1'b0, '0},
      '{bqc_pkg::OP_COEF, 8'd0, 4'd4, bqc_pkg::TERM_B0, COEF_ONE, 1'b0, '0},
      '{bqc_pkg::OP_COEF, 8'd0, 4'd5, bqc_pkg::TERM_B0, COEF_ONE, 1'b0, '0},
      '{bqc_pkg::OP_COEF, 8'd0, 4'd6, bqc_pkg::TERM_B0, COEF_ONE, 1'b0, '0},
      '{bqc_pkg::OP_COEF, 8'd0, 4'd7, bqc_pkg::TERM_B0, COEF_ONE, 1'b0, '0},
      '{bqc_pkg::OP_COEF, 8'd0, 4'd8, bqc_pkg::TERM_B0, COEF_ONE, 1'b0, '0},
      '{bqc_pkg::OP_COEF, 8'd0, 4'd9, bqc_pkg::TERM_B0, COEF_ONE, 1'b0, '0},
      '{bqc_pkg::OP_FILTER, 8'd255, 4'd0, bqc_pkg::TERM_B0, 32'd0, 1'b1,
        '{16'sd25500, 1'b0}},
      '{bqc_pkg::OP_FILTER, 8'd1, 4'd0, bqc_pkg::TERM_B0, 32'd0, 1'b1, '{16'sd100, 1'b0}},
      // largest and smallest b0 in the last section clip the output
      '{bqc_pkg::OP_COEF, 8'd0, 4'd9, bqc_pkg::TERM_B0, COEF_TOP, 1'b0, '0},
      '{bqc_pkg::OP_FILTER, 8'd255, 4'd0, bqc_pkg::TERM_B0, 32'd0, 1'b1,
        '{16'sh7FFF, 1'b1}},
      '{bqc_pkg::OP_COEF, 8'd0, 4'd9, bqc_pkg::TERM_B0, COEF_BOT, 1'b0, '0},
      '{bqc_pkg::OP_FILTER, 8'd255, 4'd0, bqc_pkg::TERM_B0, 32'd0, 1'b1,
        '{16'sh8000, 1'b1}},
      // every tap, with feedback strong enough to hit the 40-bit clamp
      '{bqc_pkg::OP_COEF, 8'd0, 4'd9, bqc_pkg::TERM_B1, 32'h0800_0000, 1'b0, '0},
      '{bqc_pkg::OP_COEF, 8'd0, 4'd9, bqc_pkg::TERM_B2, 32'hF800_0000, 1'b0, '0},
      '{bqc_pkg::OP_COEF, 8'd0, 4'd9, bqc_pkg::TERM_A1, COEF_BOT, 1'b0, '0},
      '{bqc_pkg::OP_COEF, 8'd0, 4'd9, bqc_pkg::TERM_A2, COEF_TOP, 1'b0, '0},
      '{bqc_pkg::OP_FILTER, 8'd200, 4'd0, bqc_pkg::TERM_B0, 32'd0, 1'b0, '0},
      '{bqc_pkg::OP_FILTER, 8'd255, 4'd0, bqc_pkg::TERM_B0, 32'd0, 1'b0, '0},
      '{bqc_pkg::OP_FILTER, 8'd0, 4'd0, bqc_pkg::TERM_B0, 32'd0, 1'b0, '0}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, no idling
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = directed_rows[i];
      send_item(row.op, row.smp, row.sec, row.slot, row.val, row.known, row.want);
    end
    wait_drained();

    // random episodes: a few coefficient updates, or on every sixth a full mild reload, then a burst of samples
    load_mild_set();
    while (items < RANDOM_ITEMS) begin
      phase = items * 4 / RANDOM_ITEMS;
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 80; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 80; end
        default: begin idle_pct = 29; stall_pct = 29; end
      endcase
      episode++;

      if (episode % 6 == 0) begin
        wait_drained();
        load_mild_set();
      end else begin
        n = $urandom_range(8, 1);
        for (int k = 0; k < n; k++) begin
          mode = $urandom_range(99, 0);
          if (mode < 85) begin
            // mild update of a valid coefficient
            sec  = 4'($urandom_range(SECTIONS - 1, 0));
            slot = bqc_pkg::term_t'($urandom_range(int'(bqc_pkg::TERM_A2), 0));
            val  = mild_coef(slot);
            items++;
          end else if (mode < 93) begin
            // full-range value, usually clips or blows up
            sec  = 4'($urandom_range(SECTIONS - 1, 0));
            slot = bqc_pkg::term_t'($urandom_range(int'(bqc_pkg::TERM_A2), 0));
            val  = $urandom;
            items++;
          end else begin
            // addresses the block must drop
            sec  = 4'($urandom);
            slot = bqc_pkg::term_t'($urandom);
            if ($urandom_range(1, 0)) sec = 4'($urandom_range(15, SECTIONS));
            else slot = bqc_pkg::term_t'($urandom_range(7, int'(bqc_pkg::TERM_A2) + 1));
            val  = $urandom;
          end
          send_item(bqc_pkg::OP_COEF, 8'($urandom), sec, slot, val, 1'b0, '0);
        end
      end

      // sample burst: random, held level, full-scale toggling or ramp
      n = $urandom_range(40, 5);
      mode = $urandom_range(3, 0);
      smp = 8'($urandom);
      for (int k = 0; k < n; k++) begin
        case (mode)
          0: smp = 8'($urandom);
          2: smp = (k % 2 == 0) ? 8'd255 : 8'd0;
          3: smp = smp + 8'd7;
          default: ;
        endcase
        send_item(bqc_pkg::OP_FILTER, smp, 4'($urandom), bqc_pkg::term_t'($urandom),
                  $urandom, 1'b0, '0);
        items++;
      end
    end

    // drain and let the block settle
    idle_pct = 0;
    stall_pct = 0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_readings.size() != 0)
      flag_mismatch($sformatf("%0d readings never arrived", pending_readings.size()));
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[biquad_cascade_iir_filter.f]
+incdir+rtl/core
rtl/core/bqc_pkg.sv
rtl/core/bqc_coef_mem.sv
rtl/core/bqc_hist_mem.sv
rtl/core/bqc_mac.sv
rtl/core/biquad_cascade_iir_filter.sv
rtl/core/bqc_checker.sv
bench/testbench.sv
